// File: rtl/pbpd_pkg.sv
// shared types and constants of the pcm block pathology detector
`timescale 1ns / 1ps

package pbpd_pkg;

    // channel lanes and their index width
    localparam int NUM_LANES = 2;
    localparam int LANE_W    = 1;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 16;
    localparam int MAG_W    = 16;
    localparam int SQ_W     = 31;
    localparam int SUM_W    = 31;
    localparam int ENERGY_W = 46;
    localparam int TARGET_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_COUNT_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LIMIT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_ABS_LIMIT   = 3'd5;

    // configuration reset values
    localparam logic [1:0]         RST_CHANNEL_COUNT    = 2'd2;
    localparam logic [COUNT_W-1:0] RST_CLIP_LEVEL       = 16'd32767;
    localparam logic [COUNT_W-1:0] RST_CLIP_COUNT_LIMIT = 16'd16;
    localparam logic [COUNT_W-1:0] RST_STEP_LIMIT       = 16'd30000;
    localparam logic [COUNT_W-1:0] RST_PEAK_LIMIT       = 16'd30000;
    localparam logic [COUNT_W-1:0] RST_MEAN_ABS_LIMIT   = 16'd8000;

    // running statistics of one channel
    typedef struct packed {
        logic [MAG_W-1:0]    peak;
        logic [COUNT_W-1:0]  clips;
        logic [COUNT_W-1:0]  step;
        logic [COUNT_W-1:0]  crossings;
        logic [SUM_W-1:0]    magnitude;
        logic [ENERGY_W-1:0] energy;
    } t_lane_stats;

    // one finished block as handed to the merge stage
    typedef struct packed {
        t_lane_stats [NUM_LANES-1:0] lanes;
        logic [COUNT_W-1:0]          frames;
        logic [TARGET_W-1:0]         mean_target;
        logic [LANE_W-1:0]           last_lane;
    } t_block;

    // thresholds of the pathology tests
    typedef struct packed {
        logic [COUNT_W-1:0] clip_count_limit;
        logic [COUNT_W-1:0] step_limit;
        logic [MAG_W-1:0]   peak_limit;
    } t_limits;

endpackage

// File: rtl/pbpd_lane.sv
// one channel lane: sample register, magnitude and square, running statistics
`timescale 1ns / 1ps

module pbpd_lane import pbpd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_upd,
    input  logic                       i_clr,
    input  logic                       i_first,
    input  logic [MAG_W-1:0]           i_clip_level,
    output t_lane_stats                o_stats
);

    logic signed [SAMPLE_W-1:0] r_sample;
    logic [MAG_W-1:0]           r_mag;
    logic [SQ_W-1:0]            r_sq;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [SAMPLE_W-1:0] n_prev;
    t_lane_stats                r_stats;
    t_lane_stats                n_stats;

    logic [MAG_W-1:0]    mag_in;
    logic [2*MAG_W-1:0]  sq_full;
    logic [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]   diff_abs;
    logic [COUNT_W-1:0]  step_mag;

    // magnitude and square of the incoming sample (-32768 maps to 32768)
    assign mag_in  = i_sample[SAMPLE_W-1] ? (~i_sample + 16'd1) : i_sample;
    assign sq_full = mag_in * mag_in;

    // input stage register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= i_sample;
            r_mag    <= mag_in;
            r_sq     <= sq_full[SQ_W-1:0];
        end
    end

    // step against the previous sample
    assign diff     = {r_sample[SAMPLE_W-1], r_sample} - {r_prev[SAMPLE_W-1], r_prev};
    assign diff_abs = diff[SAMPLE_W] ? (~diff + 17'd1) : diff;
    assign step_mag = diff_abs[COUNT_W-1:0];

    // statistics update
    always_comb begin
        n_stats = r_stats;
        n_prev  = r_prev;
        if (i_upd) begin
            if (r_mag > r_stats.peak) begin
                n_stats.peak = r_mag;
            end
            if (r_mag >= i_clip_level) begin
                n_stats.clips = r_stats.clips + 16'd1;
            end
            if (!i_first) begin
                if (step_mag > r_stats.step) begin
                    n_stats.step = step_mag;
                end
                if (r_sample[SAMPLE_W-1] != r_prev[SAMPLE_W-1]) begin
                    n_stats.crossings = r_stats.crossings + 16'd1;
                end
            end
            n_stats.magnitude = r_stats.magnitude + SUM_W'(r_mag);
            n_stats.energy    = r_stats.energy + ENERGY_W'(r_sq);
            n_prev            = r_sample;
        end
    end

    // running state, cleared when the block closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_stats <= '0;
            r_prev  <= '0;
        end else begin
            r_stats <= n_stats;
            r_prev  <= n_prev;
        end
    end

    // statistics including the frame in flight
    assign o_stats = n_stats;

endmodule

// File: rtl/pbpd_merge.sv
// merge stage: holds a finished block and emits one result per channel
`timescale 1ns / 1ps

module pbpd_merge import pbpd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_blk_load,
    input  t_block              i_blk,
    input  t_limits             i_limits,
    output logic                o_blk_free,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [LANE_W-1:0]   o_channel_index,
    output logic [COUNT_W-1:0]  o_frame_total,
    output logic [MAG_W-1:0]    o_peak_magnitude,
    output logic [COUNT_W-1:0]  o_clip_total,
    output logic [COUNT_W-1:0]  o_largest_step,
    output logic [COUNT_W-1:0]  o_crossing_total,
    output logic [SUM_W-1:0]    o_magnitude_sum,
    output logic [ENERGY_W-1:0] o_energy_sum,
    output logic                o_pathological,
    output logic                o_last_of_block
);

    t_block              r_blk;
    logic                r_blk_valid;
    logic [LANE_W-1:0]   r_lane;
    logic                r_out_valid;
    logic [LANE_W-1:0]   r_channel_index;
    logic [COUNT_W-1:0]  r_frame_total;
    t_lane_stats         r_out_stats;
    logic                r_pathological;
    logic                r_last;

    t_lane_stats sel;
    logic        out_free;
    logic        emit;
    logic        emit_last;
    logic        path;

    // emit control
    assign out_free   = !r_out_valid || !i_stall;
    assign emit       = r_blk_valid && out_free;
    assign emit_last  = emit && (r_lane == r_blk.last_lane);
    assign o_blk_free = !r_blk_valid || emit_last;

    // pathology tests on the selected channel
    assign sel  = r_blk.lanes[r_lane];
    assign path = (sel.clips >= i_limits.clip_count_limit)
               || (sel.step >= i_limits.step_limit)
               || ((sel.peak >= i_limits.peak_limit)
                   && ({1'b0, sel.magnitude} >= r_blk.mean_target));

    // block buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_valid <= 1'b0;
            r_lane      <= '0;
        end else if (i_blk_load) begin
            r_blk_valid <= 1'b1;
            r_lane      <= '0;
        end else if (emit_last) begin
            r_blk_valid <= 1'b0;
        end else if (emit) begin
            r_lane <= r_lane + 1'b1;
        end
    end

    // block buffer payload
    always_ff @(posedge i_clk) begin
        if (i_blk_load) begin
            r_blk <= i_blk;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_channel_index <= r_lane;
            r_frame_total   <= r_blk.frames;
            r_out_stats     <= sel;
            r_pathological  <= path;
            r_last          <= (r_lane == r_blk.last_lane);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_channel_index  = r_channel_index;
    assign o_frame_total    = r_frame_total;
    assign o_peak_magnitude = r_out_stats.peak;
    assign o_clip_total     = r_out_stats.clips;
    assign o_largest_step   = r_out_stats.step;
    assign o_crossing_total = r_out_stats.crossings;
    assign o_magnitude_sum  = r_out_stats.magnitude;
    assign o_energy_sum     = r_out_stats.energy;
    assign o_pathological   = r_pathological;
    assign o_last_of_block  = r_last;

endmodule

// File: rtl/pcm_block_pathology_detector.sv
// pcm block pathology detector top level: config, frame counter, lanes, merge
// pipeline: a closing frame goes through the accumulate register, merge block buffer
// and output register; in stereo the right channel result follows the left
// throughput: one frame per cycle while o_stall is low; a closing frame stalls the input
// until the merge stage has emitted the last result of the previous block
// reset: config registers take their defaults and all statistics clear at once
`timescale 1ns / 1ps

module pcm_block_pathology_detector import pbpd_pkg::*; #(
    parameter int unsigned MAX_FRAMES = 65535
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    // frame input
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_left,
    input  logic signed [SAMPLE_W-1:0] i_sample_right,
    input  logic                       i_block_end,
    // result output
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [LANE_W-1:0]          o_channel_index,
    output logic [COUNT_W-1:0]         o_frame_total,
    output logic [MAG_W-1:0]           o_peak_magnitude,
    output logic [COUNT_W-1:0]         o_clip_total,
    output logic [COUNT_W-1:0]         o_largest_step,
    output logic [COUNT_W-1:0]         o_crossing_total,
    output logic [SUM_W-1:0]           o_magnitude_sum,
    output logic [ENERGY_W-1:0]        o_energy_sum,
    output logic                       o_pathological,
    output logic                       o_last_of_block
);

    logic [1:0]         r_channel_count;
    logic [MAG_W-1:0]   r_clip_level;
    logic [COUNT_W-1:0] r_clip_count_limit;
    logic [COUNT_W-1:0] r_step_limit;
    logic [MAG_W-1:0]   r_peak_limit;
    logic [COUNT_W-1:0] r_mean_abs_limit;

    logic               r_s1_valid;
    logic               r_s1_end;
    logic               r_s1_stereo;
    logic [COUNT_W-1:0] r_frames;

    logic                          accept;
    logic                          s1_adv;
    logic                          s1_step;
    logic                          s1_close;
    logic                          blk_free;
    logic [COUNT_W-1:0]            frames_next;
    logic [TARGET_W-1:0]           mean_target;
    logic [NUM_LANES-1:0]          lane_upd;
    logic signed [SAMPLE_W-1:0]    lane_sample [NUM_LANES];
    t_lane_stats [NUM_LANES-1:0]   lane_stats;
    t_block                        blk;
    t_limits                       limits;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count    <= RST_CHANNEL_COUNT;
            r_clip_level       <= RST_CLIP_LEVEL;
            r_clip_count_limit <= RST_CLIP_COUNT_LIMIT;
            r_step_limit       <= RST_STEP_LIMIT;
            r_peak_limit       <= RST_PEAK_LIMIT;
            r_mean_abs_limit   <= RST_MEAN_ABS_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_COUNT:    r_channel_count    <= i_cfg_data[1:0];
                CFG_CLIP_LEVEL:       r_clip_level       <= i_cfg_data;
                CFG_CLIP_COUNT_LIMIT: r_clip_count_limit <= i_cfg_data;
                CFG_STEP_LIMIT:       r_step_limit       <= i_cfg_data;
                CFG_PEAK_LIMIT:       r_peak_limit       <= i_cfg_data;
                CFG_MEAN_ABS_LIMIT:   r_mean_abs_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accumulate stage control: a closing frame waits for the merge buffer
    assign frames_next = r_frames + 16'd1;
    assign s1_close    = r_s1_end || (frames_next >= COUNT_W'(MAX_FRAMES))
                      || (frames_next == '0);
    assign s1_adv      = !r_s1_valid || !s1_close || blk_free;
    assign s1_step     = r_s1_valid && s1_adv;
    assign o_stall     = !s1_adv;
    assign accept      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_end    <= i_block_end;
            r_s1_stereo <= r_channel_count[1];
        end
    end

    // shared frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= '0;
        end else if (s1_step) begin
            r_frames <= s1_close ? '0 : frames_next;
        end
    end

    // channel lanes: lane 0 always active, others only in stereo
    assign lane_sample[0] = i_sample_left;
    assign lane_sample[1] = i_sample_right;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        assign lane_upd[g] = s1_step && ((g == 0) || r_s1_stereo);

        pbpd_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (accept),
            .i_sample     (lane_sample[g]),
            .i_upd        (lane_upd[g]),
            .i_clr        (s1_step && s1_close),
            .i_first      (r_frames == '0),
            .i_clip_level (r_clip_level),
            .o_stats      (lane_stats[g])
        );
    end

    // mean test threshold: limit times frames of the closing block
    assign mean_target = r_mean_abs_limit * frames_next;

    // finished block record
    always_comb begin
        blk.lanes       = lane_stats;
        blk.frames      = frames_next;
        blk.mean_target = mean_target;
        blk.last_lane   = r_s1_stereo ? LANE_W'(1) : LANE_W'(0);
    end

    assign limits.clip_count_limit = r_clip_count_limit;
    assign limits.step_limit       = r_step_limit;
    assign limits.peak_limit       = r_peak_limit;

    pbpd_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_blk_load       (s1_step && s1_close),
        .i_blk            (blk),
        .i_limits         (limits),
        .o_blk_free       (blk_free),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_channel_index  (o_channel_index),
        .o_frame_total    (o_frame_total),
        .o_peak_magnitude (o_peak_magnitude),
        .o_clip_total     (o_clip_total),
        .o_largest_step   (o_largest_step),
        .o_crossing_total (o_crossing_total),
        .o_magnitude_sum  (o_magnitude_sum),
        .o_energy_sum     (o_energy_sum),
        .o_pathological   (o_pathological),
        .o_last_of_block  (o_last_of_block)
    );

    // input is held back only by a pending closing frame
    a_stall_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && s1_close))
        else $error("input stalled without a closing frame pending");

    // the right channel result always ends its block
    a_right_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_channel_index == LANE_W'(1))) |-> o_last_of_block)
        else $error("right channel result not marked last");

    // a finished block holds at least one frame
    a_frames_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_total != '0))
        else $error("result with zero frames");

    // a closed block clears the frame counter
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_step && s1_close) |=> (r_frames == '0))
        else $error("frame counter not cleared after block close");

endmodule
